@@ rtl/core/mdacc_pkg.sv @@
// Package for the morph delta accumulator: field widths, operation codes,
// default parameter values and the lane control struct. No dependencies.
package mdacc_pkg;

  localparam int unsigned DATA_W       = 16;
  localparam int unsigned IDX_W        = 10;
  localparam int unsigned WEIGHT_W     = 16;
  localparam int unsigned OP_W         = 2;
  localparam int unsigned LANES        = 3;
  localparam int unsigned WORD_W       = LANES * DATA_W;
  localparam int unsigned PROD_W       = 2 * DATA_W;

  localparam int unsigned DEF_ENTRIES  = 1024;
  localparam int unsigned DEF_WFRAC    = 12;

  // Operation codes; the spare code behaves as a read.
  localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
  localparam logic [OP_W-1:0] OP_ACCUM = 2'd1;
  localparam logic [OP_W-1:0] OP_READ  = 2'd2;

  typedef struct packed {
    logic            mul_en;
    logic [OP_W-1:0] op;
  } lane_ctrl_t;

endpackage

@@ rtl/core/mdacc_index.sv @@
// Entry index reduction: entry index modulo the store depth, done with a
// reciprocal multiply and one correction step. Depends on mdacc_pkg.
module mdacc_index #(
  parameter int unsigned ENTRIES = mdacc_pkg::DEF_ENTRIES,
  localparam int unsigned AW     = $clog2(ENTRIES)
) (
  input  logic                        clk_i,
  input  logic                        load_i,
  input  logic [mdacc_pkg::IDX_W-1:0] idx_i,
  output logic [AW-1:0]               addr_o
);
  import mdacc_pkg::*;

  localparam int unsigned RECIP_SHIFT = 20;
  localparam int unsigned RW          = 17;
  localparam int unsigned RECIP       = (1 << RECIP_SHIFT) / ENTRIES;
  localparam int unsigned PW          = IDX_W + RW;
  localparam int unsigned QW          = PW - RECIP_SHIFT;
  localparam int unsigned BW          = QW + RW;
  localparam logic [RW-1:0] RECIP_C   = RW'(RECIP);
  localparam logic [RW-1:0] ENT_C     = RW'(ENTRIES);

  logic [PW-1:0]    prod;
  logic [QW-1:0]    quot_d, quot_q;
  logic [BW-1:0]    back;
  logic [IDX_W-1:0] rem_raw, rem;

  // Quotient estimate is low by at most one.
  assign prod   = PW'(idx_i) * PW'(RECIP_C);
  assign quot_d = prod[PW-1:RECIP_SHIFT];

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      quot_q <= quot_d;
    end
  end

  assign back    = BW'(quot_q) * BW'(ENT_C);
  assign rem_raw = idx_i - back[IDX_W-1:0];
  assign rem     = (RW'(rem_raw) >= ENT_C) ? (rem_raw - ENT_C[IDX_W-1:0]) : rem_raw;
  assign addr_o  = AW'(rem);

endmodule

@@ rtl/core/mdacc_lane.sv @@
// One component lane: weight times delta, truncate toward zero, saturate,
// then load, accumulate or pass the stored value. Depends on mdacc_pkg.
module mdacc_lane #(
  parameter int unsigned WEIGHT_FRAC_BITS = mdacc_pkg::DEF_WFRAC
) (
  input  logic                                  clk_i,
  input  mdacc_pkg::lane_ctrl_t                 ctrl_i,
  input  logic signed [mdacc_pkg::WEIGHT_W-1:0] weight_i,
  input  logic signed [mdacc_pkg::DATA_W-1:0]   delta_i,
  input  logic        [mdacc_pkg::DATA_W-1:0]   stored_i,
  output logic        [mdacc_pkg::DATA_W-1:0]   result_o
);
  import mdacc_pkg::*;

  localparam logic signed [PROD_W-1:0] BIAS    = PROD_W'((1 << WEIGHT_FRAC_BITS) - 1);
  localparam logic signed [PROD_W-1:0] SAT_MAX = PROD_W'(32767);
  localparam logic signed [PROD_W-1:0] SAT_MIN = -PROD_W'(32768);

  logic signed [PROD_W-1:0] prod_q;
  logic signed [PROD_W-1:0] biased;
  logic signed [PROD_W-1:0] shifted;
  logic        [DATA_W-1:0] scaled;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) begin
      prod_q <= PROD_W'(weight_i) * PROD_W'(delta_i);
    end
  end

  // Bias negative products so the arithmetic shift rounds toward zero.
  assign biased  = prod_q[PROD_W-1] ? (prod_q + BIAS) : prod_q;
  assign shifted = biased >>> WEIGHT_FRAC_BITS;

  always_comb begin
    if (shifted > SAT_MAX) begin
      scaled = SAT_MAX[DATA_W-1:0];
    end else if (shifted < SAT_MIN) begin
      scaled = SAT_MIN[DATA_W-1:0];
    end else begin
      scaled = shifted[DATA_W-1:0];
    end
  end

  always_comb begin
    case (ctrl_i.op)
      OP_LOAD:  result_o = delta_i;
      OP_ACCUM: result_o = stored_i + scaled;
      default:  result_o = stored_i;
    endcase
  end

endmodule

@@ rtl/core/mdacc_merge.sv @@
// Merge stage: packs the lane results into one store word and holds the
// result beat until the receiver takes it. Depends on mdacc_pkg.
module mdacc_merge (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  load_i,
  input  logic [mdacc_pkg::DATA_W-1:0]          lane_x_i,
  input  logic [mdacc_pkg::DATA_W-1:0]          lane_y_i,
  input  logic [mdacc_pkg::DATA_W-1:0]          lane_z_i,
  output logic [mdacc_pkg::WORD_W-1:0]          word_o,
  output logic                                  full_o,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic signed [mdacc_pkg::DATA_W-1:0]   value_x_o,
  output logic signed [mdacc_pkg::DATA_W-1:0]   value_y_o,
  output logic signed [mdacc_pkg::DATA_W-1:0]   value_z_o
);
  import mdacc_pkg::*;

  logic              valid_q, valid_d;
  logic [WORD_W-1:0] word_q;

  assign word_o = {lane_x_i, lane_y_i, lane_z_i};

  always_comb begin
    valid_d = valid_q;
    if (out_ready_i) begin
      valid_d = 1'b0;
    end
    if (load_i) begin
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      word_q <= word_o;
    end
  end

  // Hold a stalled beat; the sequencer loads only when this is free.
  assign full_o      = valid_q && !out_ready_i;
  assign out_valid_o = valid_q;
  assign value_x_o   = word_q[3*DATA_W-1:2*DATA_W];
  assign value_y_o   = word_q[2*DATA_W-1:DATA_W];
  assign value_z_o   = word_q[DATA_W-1:0];

endmodule

@@ rtl/core/morph_delta_accumulator.sv @@
// Morph delta accumulator top level: sequencer, delta store and lanes.
// Depends on mdacc_pkg, mdacc_index, mdacc_lane and mdacc_merge.
//
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries one item per beat:
//   operation, entry index, Q-format weight and an x/y/z delta triple.
//   Load writes the triple into the entry, accumulate adds the weighted,
//   truncated and saturated triple into it with 16-bit wrap, read leaves
//   it alone. Every item gives one result beat on the output channel
//   (out_valid_o / out_ready_i) with the entry's value after the operation.
//   The result beat is registered at write-back, after index reduction and
//   the store read. Items are taken one at a time: the sequencer walks
//   through index reduction, store read, multiply and store write-back on
//   the single-port store before it accepts the next item.
//   The index is reduced modulo ENTRIES by a reciprocal multiply.
//   Reset clears the sequencer and the output valid; the store itself is
//   not cleared, so an entry must be loaded before it is read or
//   accumulated. When the receiver stalls, the result beat is held in the
//   output register and the next item is still accepted; that item waits
//   at write-back until the held beat is taken.
module morph_delta_accumulator #(
  parameter int unsigned ENTRIES          = mdacc_pkg::DEF_ENTRIES,
  parameter int unsigned WEIGHT_FRAC_BITS = mdacc_pkg::DEF_WFRAC
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic [mdacc_pkg::OP_W-1:0]            operation_i,
  input  logic [mdacc_pkg::IDX_W-1:0]           entry_index_i,
  input  logic signed [mdacc_pkg::WEIGHT_W-1:0] weight_i,
  input  logic signed [mdacc_pkg::DATA_W-1:0]   delta_x_i,
  input  logic signed [mdacc_pkg::DATA_W-1:0]   delta_y_i,
  input  logic signed [mdacc_pkg::DATA_W-1:0]   delta_z_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic signed [mdacc_pkg::DATA_W-1:0]   value_x_o,
  output logic signed [mdacc_pkg::DATA_W-1:0]   value_y_o,
  output logic signed [mdacc_pkg::DATA_W-1:0]   value_z_o
);
  import mdacc_pkg::*;

  localparam int unsigned AW = $clog2(ENTRIES);

  // Sequencer codes
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_IDX  = 2'd1;
  localparam logic [1:0] S_RD   = 2'd2;
  localparam logic [1:0] S_WB   = 2'd3;

  logic [1:0]                state_q, state_d;
  logic                      accept;
  logic                      wb_go;
  logic                      merge_full;

  // Captured item
  logic [OP_W-1:0]           op_q;
  logic [IDX_W-1:0]          idx_q;
  logic signed [WEIGHT_W-1:0] weight_q;
  logic signed [DATA_W-1:0]  delta_q [LANES];

  // Store
  logic [WORD_W-1:0]         mem_q [ENTRIES];
  logic [WORD_W-1:0]         rdata_q;
  logic [WORD_W-1:0]         wdata;
  logic [AW-1:0]             rd_addr;
  logic [AW-1:0]             addr_q;

  logic [DATA_W-1:0]         stored [LANES];
  logic [DATA_W-1:0]         lane_res [LANES];
  lane_ctrl_t                lane_ctrl;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign wb_go      = (state_q == S_WB) && !merge_full;

  // Advance one step per cycle; wait at write-back while the output is full.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (accept) state_d = S_IDX;
      S_IDX:   state_d = S_RD;
      S_RD:    state_d = S_WB;
      S_WB:    if (!merge_full) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q       <= operation_i;
      idx_q      <= entry_index_i;
      weight_q   <= weight_i;
      delta_q[0] <= delta_x_i;
      delta_q[1] <= delta_y_i;
      delta_q[2] <= delta_z_i;
    end
  end

  mdacc_index #(
    .ENTRIES (ENTRIES)
  ) u_index (
    .clk_i  (clk_i),
    .load_i (state_q == S_IDX),
    .idx_i  (idx_q),
    .addr_o (rd_addr)
  );

  // Read in the read step, write back the merged word at write-back.
  always_ff @(posedge clk_i) begin
    if (state_q == S_RD) begin
      rdata_q <= mem_q[rd_addr];
      addr_q  <= rd_addr;
    end
    if (wb_go) begin
      mem_q[addr_q] <= wdata;
    end
  end

  assign stored[0] = rdata_q[3*DATA_W-1:2*DATA_W];
  assign stored[1] = rdata_q[2*DATA_W-1:DATA_W];
  assign stored[2] = rdata_q[DATA_W-1:0];

  // Multiply during index reduction; the product is ready by write-back.
  assign lane_ctrl.mul_en = (state_q == S_IDX);
  assign lane_ctrl.op     = op_q;

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    mdacc_lane #(
      .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
    ) u_lane (
      .clk_i    (clk_i),
      .ctrl_i   (lane_ctrl),
      .weight_i (weight_q),
      .delta_i  (delta_q[l]),
      .stored_i (stored[l]),
      .result_o (lane_res[l])
    );
  end

  mdacc_merge u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (wb_go),
    .lane_x_i    (lane_res[0]),
    .lane_y_i    (lane_res[1]),
    .lane_z_i    (lane_res[2]),
    .word_o      (wdata),
    .full_o      (merge_full),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .value_x_o   (value_x_o),
    .value_y_o   (value_y_o),
    .value_z_o   (value_z_o)
  );

  // Every write-back step that goes ahead leaves a result beat pending.
  a_wb_gives_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wb_go |=> out_valid_o)
    else $error("write-back without result beat");

  // An accepted beat starts index reduction in the next cycle.
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == S_IDX))
    else $error("accepted beat did not start the sequencer");

  // The reduced index always addresses an entry of the store.
  a_addr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WB) |-> ((AW+1)'(addr_q) < (AW+1)'(ENTRIES)))
    else $error("store address beyond depth");

  // A stalled result beat is never overwritten by a later item.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |-> !wb_go)
    else $error("pending result overwritten");

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for morph_delta_accumulator: a directed table, then random
// load/accumulate/read traffic checked against a cycle-free model of the delta store.
// Depends on mdacc_pkg and the RTL top level only.
module tb_top;
  import mdacc_pkg::*;

  localparam int unsigned STORE_DEPTH  = DEF_ENTRIES;
  localparam int unsigned FRAC_BITS    = DEF_WFRAC;
  localparam logic [OP_W-1:0] OP_SPARE = 2'd3;    // unused code, behaves as a read
  localparam int DIRECTED_ROWS = 22;
  localparam int RANDOM_ITEMS  = 650;
  localparam int PHASE_ITEMS   = 65;               // items between traffic-shape changes
  localparam int HOT_ENTRIES   = 8;                // entries that take most accumulates
  localparam int MAX_IDLE      = 6;
  localparam int STALL_LIMIT   = 2000;             // cycles with no beat on either side
  localparam int TAIL_CYCLES   = 20;               // margin after the last owed result
  localparam int REPORT_LIMIT  = 10;

  typedef struct packed {
    logic [DATA_W-1:0] x;
    logic [DATA_W-1:0] y;
    logic [DATA_W-1:0] z;
  } triple_t;

  // One stimulus row; typed rows carry a hand-written expected value.
  typedef struct packed {
    logic [OP_W-1:0]     op;
    logic [IDX_W-1:0]    idx;
    logic [WEIGHT_W-1:0] weight;
    triple_t             delta;
    bit                  typed;
    triple_t             value;
  } stim_row_t;

  logic                clk           = 1'b0;
  logic                rst_n         = 1'b0;
  logic                in_valid      = 1'b0;
  logic                in_ready;
  logic [OP_W-1:0]     operation     = OP_READ;
  logic [IDX_W-1:0]    entry_index   = '0;
  logic [WEIGHT_W-1:0] weight        = '0;
  logic [DATA_W-1:0]   delta_x       = '0;
  logic [DATA_W-1:0]   delta_y       = '0;
  logic [DATA_W-1:0]   delta_z       = '0;
  logic                out_valid;
  logic                out_ready     = 1'b0;
  logic [DATA_W-1:0]   value_x;
  logic [DATA_W-1:0]   value_y;
  logic [DATA_W-1:0]   value_z;

  // Shadow of the delta store and which entries hold a loaded value.
  triple_t mirror_store [STORE_DEPTH];
  bit      entry_loaded [STORE_DEPTH];
  int      loaded_list  [$];
  triple_t entry_values [$];      // entry values still owed by the block, oldest first

  bit zero_idle = 1'b0;           // both sides run back to back while set
  int mismatches = 0;
  int idle_cycles = 0;
  int n_loads = 0, n_accums = 0, n_reads = 0, n_spares = 0, n_saturated = 0;

  stim_row_t stim_table [DIRECTED_ROWS] = '{
    // extremes loaded and read back
    '{OP_LOAD,  10'h000, 16'h1234, '{16'h7FFF, 16'h8000, 16'h0000}, 1'b1,
      '{16'h7FFF, 16'h8000, 16'h0000}},
    '{OP_READ,  10'h000, 16'hFFFF, '{16'hFFFF, 16'hFFFF, 16'hFFFF}, 1'b1,
      '{16'h7FFF, 16'h8000, 16'h0000}},
    '{OP_LOAD,  10'h3FF, 16'hFFFF, '{16'h0000, 16'h0000, 16'h0000}, 1'b1,
      '{16'h0000, 16'h0000, 16'h0000}},
    // most negative weight: products saturate both ways
    '{OP_ACCUM, 10'h3FF, 16'h8000, '{16'h8000, 16'h7FFF, 16'h0000}, 1'b1,
      '{16'h7FFF, 16'h8000, 16'h0000}},
    // most positive weight: saturated adds wrap
    '{OP_ACCUM, 10'h3FF, 16'h7FFF, '{16'h7FFF, 16'h8000, 16'h0001}, 1'b1,
      '{16'hFFFE, 16'h0000, 16'h0007}},
    '{OP_SPARE, 10'h3FF, 16'h0000, '{16'h1234, 16'h5678, 16'h9ABC}, 1'b1,
      '{16'hFFFE, 16'h0000, 16'h0007}},
    '{OP_LOAD,  10'h005, 16'h0000, '{16'h7FFF, 16'h8000, 16'hFFFF}, 1'b1,
      '{16'h7FFF, 16'h8000, 16'hFFFF}},
    // unit weight: stored value wraps past the 16-bit range
    '{OP_ACCUM, 10'h005, 16'h1000, '{16'h0001, 16'hFFFF, 16'h0001}, 1'b1,
      '{16'h8000, 16'h7FFF, 16'h0000}},
    // tiny weights: truncation toward zero
    '{OP_ACCUM, 10'h005, 16'h0001, '{16'hFFFF, 16'h0001, 16'h8000}, 1'b0, '0},
    '{OP_ACCUM, 10'h005, 16'hFFFF, '{16'h7FFF, 16'h8000, 16'h1001}, 1'b0, '0},
    '{OP_LOAD,  10'h2AA, 16'hAAAA, '{16'h5555, 16'hAAAA, 16'h1234}, 1'b1,
      '{16'h5555, 16'hAAAA, 16'h1234}},
    '{OP_ACCUM, 10'h2AA, 16'hF000, '{16'h5555, 16'hAAAA, 16'h1234}, 1'b0, '0},
    '{OP_ACCUM, 10'h2AA, 16'h0000, '{16'h7FFF, 16'h8000, 16'hFFFF}, 1'b0, '0},
    // back-to-back writes to one entry
    '{OP_LOAD,  10'h155, 16'h5555, '{16'hAAAA, 16'h5555, 16'hEDCB}, 1'b1,
      '{16'hAAAA, 16'h5555, 16'hEDCB}},
    '{OP_LOAD,  10'h155, 16'h0000, '{16'h0100, 16'hFF00, 16'h0000}, 1'b1,
      '{16'h0100, 16'hFF00, 16'h0000}},
    '{OP_ACCUM, 10'h155, 16'h4000, '{16'h2000, 16'hE000, 16'h0FFF}, 1'b0, '0},
    '{OP_READ,  10'h155, 16'h7FFF, '{16'h8000, 16'h7FFF, 16'h0000}, 1'b0, '0},
    '{OP_ACCUM, 10'h000, 16'h7FFF, '{16'h0001, 16'h0001, 16'h0001}, 1'b0, '0},
    '{OP_READ,  10'h3FF, 16'h8000, '{16'h0000, 16'h7FFF, 16'h8000}, 1'b1,
      '{16'hFFFE, 16'h0000, 16'h0007}},
    '{OP_SPARE, 10'h155, 16'h1000, '{16'hFFFF, 16'hFFFF, 16'hFFFF}, 1'b0, '0},
    '{OP_ACCUM, 10'h155, 16'h8001, '{16'h8000, 16'h7FFF, 16'hFFFF}, 1'b0, '0},
    '{OP_READ,  10'h005, 16'h0000, '{16'h0000, 16'h0000, 16'h0000}, 1'b0, '0}
  };

  morph_delta_accumulator u_top (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .operation_i   (operation),
    .entry_index_i (entry_index),
    .weight_i      (weight),
    .delta_x_i     (delta_x),
    .delta_y_i     (delta_y),
    .delta_z_i     (delta_z),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .value_x_o     (value_x),
    .value_y_o     (value_y),
    .value_z_o     (value_z)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Scale one component by a Q-format weight: exact product, shift with
  // truncation toward zero, saturate to 16 bits.
  function automatic logic [DATA_W-1:0] weigh_component(input logic signed [WEIGHT_W-1:0] w,
                                                         input logic signed [DATA_W-1:0] d);
    longint prod;
    longint q;
    prod = longint'(w) * longint'(d);
    if (prod < 0) q = -((-prod) >>> FRAC_BITS);
    else          q = prod >>> FRAC_BITS;
    if (q > 32767) begin
      q = 32767;
      n_saturated++;
    end else if (q < -32768) begin
      q = -32768;
      n_saturated++;
    end
    return q[DATA_W-1:0];
  endfunction

  // Apply one item to the shadow store and return the entry afterwards.
  function automatic triple_t blend_entry(input stim_row_t row);
    int      slot;
    triple_t e;
    slot = int'(row.idx) % STORE_DEPTH;
    e = mirror_store[slot];
    case (row.op)
      OP_LOAD: begin
        e = row.delta;
        n_loads++;
        if (!entry_loaded[slot]) begin
          entry_loaded[slot] = 1'b1;
          loaded_list.push_back(slot);
        end
      end
      OP_ACCUM: begin
        e.x = e.x + weigh_component(row.weight, row.delta.x);
        e.y = e.y + weigh_component(row.weight, row.delta.y);
        e.z = e.z + weigh_component(row.weight, row.delta.z);
        n_accums++;
      end
      OP_READ:  n_reads++;
      default:  n_spares++;
    endcase
    mirror_store[slot] = e;
    return e;
  endfunction

  // Offer one item after a random gap, hold it until taken, then record
  // the entry value it must produce.
  task automatic send_item(input stim_row_t row);
    int      gap;
    triple_t predicted;
    gap = zero_idle ? 0 : $urandom_range(0, MAX_IDLE);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    operation   <= row.op;
    entry_index <= row.idx;
    weight      <= row.weight;
    delta_x     <= row.delta.x;
    delta_y     <= row.delta.y;
    delta_z     <= row.delta.z;
    do @(posedge clk); while (!in_ready);
    predicted = blend_entry(row);
    entry_values.push_back(row.typed ? row.value : predicted);
  endtask

  function automatic logic [DATA_W-1:0] pick_delta();
    logic [DATA_W-1:0] corners [5] = '{16'h7FFF, 16'h8000, 16'h0000, 16'h0001, 16'hFFFF};
    case ($urandom_range(0, 4))
      0:       return corners[$urandom_range(0, 4)];
      1:       return DATA_W'($urandom_range(0, 511)) - DATA_W'(256);
      default: return DATA_W'($urandom());
    endcase
  endfunction

  // Receiver: stall for a random number of cycles before each result beat.
  initial begin
    int stall;
    wait (rst_n === 1'b1);
    forever begin
      stall = zero_idle ? 0 : $urandom_range(0, MAX_IDLE);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Check every result beat against the oldest owed entry value.
  always @(posedge clk) begin
    triple_t got;
    triple_t want;
    if (rst_n && out_valid && out_ready) begin
      got = '{value_x, value_y, value_z};
      if (entry_values.size() == 0) begin
        if (mismatches < REPORT_LIMIT)
          $display("[%0t] result beat with nothing owed: x=%h y=%h z=%h",
                   $realtime, got.x, got.y, got.z);
        mismatches++;
      end else begin
        want = entry_values.pop_front();
        if (got.x !== want.x || got.y !== want.y || got.z !== want.z) begin
          if (mismatches < REPORT_LIMIT)
            $display("[%0t] entry value wrong: expected x=%h y=%h z=%h, got x=%h y=%h z=%h",
                     $realtime, want.x, want.y, want.z, got.x, got.y, got.z);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: end the run when no beat moves for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("watchdog: no beat for %0d cycles, %0d results still owed",
                 STALL_LIMIT, entry_values.size());
        $display("morph_delta_accumulator: mismatch");
        $finish;
      end
    end
  end

  initial begin
    stim_row_t row;
    int        hot_set [HOT_ENTRIES];
    int        pick;
    logic [WEIGHT_W-1:0] weight_corners [7];
    weight_corners = '{16'h7FFF, 16'h8000, 16'h0000, 16'h1000,
                       16'hF000, 16'h0001, 16'hFFFF};
    foreach (mirror_store[i]) begin
      mirror_store[i] = '0;
      entry_loaded[i] = 1'b0;
    end
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table: corners, every operation, truncation and wrap.
    for (int r = 0; r < DIRECTED_ROWS; r++) send_item(stim_table[r]);

    // Random traffic: mostly load-then-accumulate runs on a few hot entries,
    // with scattered loads and reads of any loaded entry mixed in.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % PHASE_ITEMS == 0) begin
        zero_idle = ($urandom_range(0, 3) == 0);
        foreach (hot_set[k]) hot_set[k] = $urandom_range(0, STORE_DEPTH - 1);
      end
      pick = $urandom_range(0, 99);
      row = '0;
      if (pick < 10) begin
        row.op  = OP_LOAD;
        row.idx = IDX_W'($urandom_range(0, STORE_DEPTH - 1));
      end else if (pick < 20) begin
        row.op  = $urandom_range(0, 1) ? OP_READ : OP_SPARE;
        row.idx = IDX_W'(loaded_list[$urandom_range(0, loaded_list.size() - 1)]);
      end else begin
        row.idx = IDX_W'(hot_set[$urandom_range(0, HOT_ENTRIES - 1)]);
        // never touch an entry before it holds a loaded value
        if (!entry_loaded[row.idx] || pick < 35) row.op = OP_LOAD;
        else if (pick < 90)                     row.op = OP_ACCUM;
        else row.op = ($urandom_range(0, 3) == 0) ? OP_SPARE : OP_READ;
      end
      case ($urandom_range(0, 3))
        0:       row.weight = WEIGHT_W'($urandom());
        1:       row.weight = WEIGHT_W'($urandom_range(0, 8192)) - WEIGHT_W'(4096);
        2:       row.weight = weight_corners[$urandom_range(0, 6)];
        default: row.weight = WEIGHT_W'($urandom_range(0, 255)) - WEIGHT_W'(128);
      endcase
      row.delta = '{pick_delta(), pick_delta(), pick_delta()};
      send_item(row);
    end
    in_valid <= 1'b0;

    // Drain owed results, then watch a little longer for stray beats.
    while (entry_values.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d items: %0d loads, %0d accumulates, %0d reads, %0d spare-code reads",
             DIRECTED_ROWS + RANDOM_ITEMS, n_loads, n_accums, n_reads, n_spares);
    $display("%0d scaled components saturated, %0d entries loaded, %0d mismatches",
             n_saturated, loaded_list.size(), mismatches);
    if (mismatches == 0 && entry_values.size() == 0) begin
      $display("morph_delta_accumulator: match");
    end else begin
      $display("morph_delta_accumulator: mismatch");
    end
    $finish;
  end

endmodule
